/* sv/ptc_pkg.sv */
package ptc_pkg;

  // Width of the pressure quotient and of the divider datapath
  localparam int DivBits = 64;

  // Calibration register indexes, one per 8-byte slot
  typedef enum logic [1:0] {
    REG_CALIB_TEMP,
    REG_CALIB_PRESS_A,
    REG_CALIB_PRESS_B,
    REG_CALIB_PRESS_P9
  } reg_idx_t;

  // Result fields that ride alongside the division
  typedef struct packed {
    logic signed [25:0] tfine;
    logic signed [15:0] temp_c;
    logic               dz;
    logic               qneg;
  } div_side_t;

endpackage

/* sv/ptc_div.sv */
module ptc_div
  import ptc_pkg::*;
(
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_vld,
  input  logic [DivBits-1:0]  in_num,
  input  logic [DivBits-1:0]  in_den,
  input  div_side_t           in_side,
  output logic                out_vld,
  output logic [DivBits-1:0]  out_quo,
  output div_side_t           out_side
);

  // One restoring step per stage; the numerator shifts out on top while
  // quotient bits shift in at the bottom.
  logic [DivBits-1:0] rem_r  [1:DivBits];
  logic [DivBits-1:0] nq_r   [1:DivBits];
  logic [DivBits-1:0] den_r  [1:DivBits];
  div_side_t          side_r [1:DivBits];
  logic               vld_r  [1:DivBits];

  for (genvar k = 0; k < DivBits; k++) begin : g_stage
    logic [DivBits-1:0] rem_in;
    logic [DivBits-1:0] nq_in;
    logic [DivBits-1:0] den_in;
    div_side_t          side_in;
    logic               vld_in;
    logic [DivBits:0]   trial;
    logic               ge;
    logic [DivBits-1:0] rem_nxt;
    logic [DivBits-1:0] nq_nxt;

    if (k == 0) begin : g_first
      assign rem_in  = '0;
      assign nq_in   = in_num;
      assign den_in  = in_den;
      assign side_in = in_side;
      assign vld_in  = in_vld;
    end else begin : g_next
      assign rem_in  = rem_r[k];
      assign nq_in   = nq_r[k];
      assign den_in  = den_r[k];
      assign side_in = side_r[k];
      assign vld_in  = vld_r[k];
    end

    // Compare shifted remainder with the divisor, subtract when it fits
    always_comb begin
      trial   = {rem_in, nq_in[DivBits-1]};
      ge      = (trial >= {1'b0, den_in});
      rem_nxt = ge ? DivBits'(trial - {1'b0, den_in}) : trial[DivBits-1:0];
      nq_nxt  = {nq_in[DivBits-2:0], ge};
    end

    // Advance payload
    always_ff @(posedge clk) begin
      rem_r[k+1]  <= rem_nxt;
      nq_r[k+1]   <= nq_nxt;
      den_r[k+1]  <= den_in;
      side_r[k+1] <= side_in;
    end

    // Advance valid
    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[k+1] <= 1'b0;
      end else begin
        vld_r[k+1] <= vld_in;
      end
    end
  end

  assign out_vld  = vld_r[DivBits];
  assign out_quo  = nq_r[DivBits];
  assign out_side = side_r[DivBits];

endmodule

/* sv/pressure_temperature_compensation_unit.sv */
// Channel   | Ports                                   | Handshake
// ----------+-----------------------------------------+-------------------------------
// input     | in_adc_pressure, in_adc_temperature     | start high, busy low
// result    | out_fine_temperature, out_temperature_  | out_strobe, one cycle, no stall
//           | centi, out_pressure_q24_8, out_divide_by_zero |
// config    | psel penable pwrite paddr pwdata prdata | write on access cycle, pready=1
//
// One item per cycle; the pipeline is the 64-stage restoring divider (one
// quotient bit per stage) plus 11 stages before it and 6 after it.
// busy stays low; reset clears only valid bits and calibration registers.
// Results cannot be held off, so the pipeline never stalls.
module pressure_temperature_compensation_unit
  import ptc_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  logic [19:0]        in_adc_pressure,
  input  logic [19:0]        in_adc_temperature,
  output logic               out_strobe,
  output logic signed [31:0] out_fine_temperature,
  output logic signed [15:0] out_temperature_centi,
  output logic [31:0]        out_pressure_q24_8,
  output logic               out_divide_by_zero,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [4:0]         paddr,
  input  logic [63:0]        pwdata,
  output logic [63:0]        prdata,
  output logic               pready
);

  localparam logic signed [26:0] TfineOffset = 27'sd128000;
  localparam logic [20:0]        PressBase   = 21'd1048576;
  localparam logic [63:0]        NumScale    = 64'd3125;
  localparam logic [63:0]        OneShl47    = 64'h0000_8000_0000_0000;

  // ---------------------------------------------------------------- config
  logic [47:0] calib_temp_r;
  logic [63:0] calib_press_a_r;
  logic [63:0] calib_press_b_r;
  logic [15:0] calib_press_p9_r;
  reg_idx_t    cfg_idx;

  assign pready  = 1'b1;
  assign cfg_idx = reg_idx_t'(paddr[4:3]);

  // Write a register on the access cycle
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      calib_temp_r     <= '0;
      calib_press_a_r  <= '0;
      calib_press_b_r  <= '0;
      calib_press_p9_r <= '0;
    end else if (psel && penable && pwrite && pready) begin
      case (cfg_idx)
        REG_CALIB_TEMP:     calib_temp_r     <= pwdata[47:0];
        REG_CALIB_PRESS_A:  calib_press_a_r  <= pwdata;
        REG_CALIB_PRESS_B:  calib_press_b_r  <= pwdata;
        REG_CALIB_PRESS_P9: calib_press_p9_r <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  // Read back
  always_comb begin
    case (cfg_idx)
      REG_CALIB_TEMP:     prdata = {16'b0, calib_temp_r};
      REG_CALIB_PRESS_A:  prdata = calib_press_a_r;
      REG_CALIB_PRESS_B:  prdata = calib_press_b_r;
      REG_CALIB_PRESS_P9: prdata = {48'b0, calib_press_p9_r};
      default:            prdata = '0;
    endcase
  end

  // Coefficients
  logic [15:0]        t1, p1;
  logic signed [15:0] t2, t3, p2, p3, p4, p5, p6, p7, p8, p9;

  assign t1 = calib_temp_r[15:0];
  assign t2 = $signed(calib_temp_r[31:16]);
  assign t3 = $signed(calib_temp_r[47:32]);
  assign p1 = calib_press_a_r[15:0];
  assign p2 = $signed(calib_press_a_r[31:16]);
  assign p3 = $signed(calib_press_a_r[47:32]);
  assign p4 = $signed(calib_press_a_r[63:48]);
  assign p5 = $signed(calib_press_b_r[15:0]);
  assign p6 = $signed(calib_press_b_r[31:16]);
  assign p7 = $signed(calib_press_b_r[47:32]);
  assign p8 = $signed(calib_press_b_r[63:48]);
  assign p9 = $signed(calib_press_p9_r);

  assign busy = 1'b0;

  // Valid bits of the stages before and after the divider
  logic [10:0] pre_vld_r;
  logic [5:0]  post_vld_r;
  logic        div_vld;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pre_vld_r  <= '0;
      post_vld_r <= '0;
    end else begin
      pre_vld_r  <= {pre_vld_r[9:0], start};
      post_vld_r <= {post_vld_r[4:0], div_vld};
    end
  end

  // ------------------------------------------------- stage 1: offsets
  logic signed [17:0] ta_nxt, ta_r;
  logic signed [16:0] td_nxt, td_r;
  logic [20:0]        pd_nxt;
  logic [20:0]        pd_r [1:8];

  always_comb begin
    ta_nxt = $signed({1'b0, in_adc_temperature[19:3]}) - $signed({1'b0, t1, 1'b0});
    td_nxt = $signed({1'b0, in_adc_temperature[19:4]}) - $signed({1'b0, t1});
    pd_nxt = PressBase - {1'b0, in_adc_pressure};
  end

  always_ff @(posedge clk) begin
    ta_r     <= ta_nxt;
    td_r     <= td_nxt;
    pd_r[1]  <= pd_nxt;
    for (int i = 2; i <= 8; i++) begin
      pd_r[i] <= pd_r[i-1];
    end
  end

  // ------------------------------------------------- stage 2: products
  logic signed [33:0] ma_nxt, ma_r;
  logic signed [33:0] dd_nxt, dd_r;

  always_comb begin
    ma_nxt = ta_r * t2;
    dd_nxt = td_r * td_r;
  end

  always_ff @(posedge clk) begin
    ma_r <= ma_nxt;
    dd_r <= dd_nxt;
  end

  // ------------------------------------------------- stage 3: T3 term
  logic signed [22:0] ta3_nxt, ta3_r;
  logic signed [22:0] dd12;
  logic signed [38:0] bp_nxt, bp_r;

  always_comb begin
    ta3_nxt = 23'(ma_r >>> 11);
    dd12    = $signed({1'b0, dd_r[33:12]});
    bp_nxt  = dd12 * t3;
  end

  always_ff @(posedge clk) begin
    ta3_r <= ta3_nxt;
    bp_r  <= bp_nxt;
  end

  // ------------------------------------------------- stage 4: t_fine
  logic signed [25:0] tfine_nxt, tfine_r;

  always_comb begin
    tfine_nxt = 26'(ta3_r) + 26'(bp_r >>> 14);
  end

  always_ff @(posedge clk) begin
    tfine_r <= tfine_nxt;
  end

  // ------------------------------------- stage 5: centi degrees, v1 offset
  logic signed [29:0] t5;
  logic signed [29:0] tcf;
  logic signed [15:0] tc;
  logic signed [26:0] v1_nxt, v1_r;
  div_side_t          side5_nxt;
  div_side_t          side_r [5:10];

  always_comb begin
    t5  = 30'(tfine_r) * 30'sd5 + 30'sd128;
    tcf = t5 >>> 8;
    if (tcf > 30'sd32767) begin
      tc = 16'sh7fff;
    end else if (tcf < -30'sd32768) begin
      tc = 16'sh8000;
    end else begin
      tc = tcf[15:0];
    end
    v1_nxt           = 27'(tfine_r) - TfineOffset;
    side5_nxt.tfine  = tfine_r;
    side5_nxt.temp_c = tc;
    side5_nxt.dz     = 1'b0;
    side5_nxt.qneg   = 1'b0;
  end

  always_ff @(posedge clk) begin
    v1_r      <= v1_nxt;
    side_r[5] <= side5_nxt;
    for (int i = 6; i <= 10; i++) begin
      side_r[i] <= side_r[i-1];
    end
  end

  // ------------------------------------------------- stage 6: v1 products
  logic signed [53:0] v1sq_nxt, v1sq_r;
  logic signed [42:0] v1p5_nxt, v1p5_r, v1p5_s7_r;
  logic signed [42:0] v1p2_nxt, v1p2_r, v1p2_s7_r;

  always_comb begin
    v1sq_nxt = v1_r * v1_r;
    v1p5_nxt = v1_r * p5;
    v1p2_nxt = v1_r * p2;
  end

  always_ff @(posedge clk) begin
    v1sq_r <= v1sq_nxt;
    v1p5_r <= v1p5_nxt;
    v1p2_r <= v1p2_nxt;
  end

  // ------------------------------------------------- stage 7: square terms
  logic signed [63:0] m6_nxt, m6_r;
  logic signed [63:0] m3_nxt, m3_r;

  always_comb begin
    m6_nxt = v1sq_r * p6;
    m3_nxt = v1sq_r * p3;
  end

  always_ff @(posedge clk) begin
    m6_r      <= m6_nxt;
    m3_r      <= m3_nxt;
    v1p5_s7_r <= v1p5_r;
    v1p2_s7_r <= v1p2_r;
  end

  // ------------------------------------------------- stage 8: sums
  logic signed [63:0] v2_nxt, v2_r;
  logic signed [63:0] u1_nxt, u1_r;

  always_comb begin
    v2_nxt = m6_r + (64'(v1p5_s7_r) <<< 17) + (64'(p4) <<< 35);
    u1_nxt = (m3_r >>> 8) + (64'(v1p2_s7_r) <<< 12);
  end

  always_ff @(posedge clk) begin
    v2_r <= v2_nxt;
    u1_r <= u1_nxt;
  end

  // ------------------------------------------------- stage 9: operands
  logic [63:0] w_nxt, w_r;
  logic [63:0] n0_nxt, n0_r;

  always_comb begin
    w_nxt  = u1_r + OneShl47;
    n0_nxt = ({43'b0, pd_r[8]} << 31) - v2_r;
  end

  always_ff @(posedge clk) begin
    w_r  <= w_nxt;
    n0_r <= n0_nxt;
  end

  // ------------------------------------------------- stage 10: scale
  logic [63:0] pf_nxt, pf_r;
  logic [63:0] num_nxt, num_r;

  always_comb begin
    pf_nxt  = w_r * {48'b0, p1};
    num_nxt = n0_r * NumScale;
  end

  always_ff @(posedge clk) begin
    pf_r  <= pf_nxt;
    num_r <= num_nxt;
  end

  // ------------------------------------------------- stage 11: magnitudes
  logic [63:0] den;
  logic [63:0] nmag_nxt, nmag_r;
  logic [63:0] dmag_nxt, dmag_r;
  div_side_t   side11_nxt, side11_r;

  always_comb begin
    den             = 64'($signed(pf_r) >>> 33);
    nmag_nxt        = num_r[63] ? (~num_r + 64'd1) : num_r;
    dmag_nxt        = den[63] ? (~den + 64'd1) : den;
    side11_nxt      = side_r[10];
    side11_nxt.dz   = (den == 64'd0);
    side11_nxt.qneg = num_r[63] ^ den[63];
  end

  always_ff @(posedge clk) begin
    nmag_r   <= nmag_nxt;
    dmag_r   <= dmag_nxt;
    side11_r <= side11_nxt;
  end

  // ------------------------------------------------- divider
  logic [DivBits-1:0] quo;
  div_side_t          dside;

  ptc_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_vld   (pre_vld_r[10]),
    .in_num   (nmag_r),
    .in_den   (dmag_r),
    .in_side  (side11_r),
    .out_vld  (div_vld),
    .out_quo  (quo),
    .out_side (dside)
  );

  // ------------------------------------------------- post 1: sign
  logic [63:0] p_nxt, p_r;
  div_side_t   ps_r [1:5];

  always_comb begin
    p_nxt = dside.qneg ? (~quo + 64'd1) : quo;
  end

  always_ff @(posedge clk) begin
    p_r     <= p_nxt;
    ps_r[1] <= dside;
    for (int i = 2; i <= 5; i++) begin
      ps_r[i] <= ps_r[i-1];
    end
  end

  // ------------------------------------------------- post 2: P9, P8 terms
  logic [63:0] q_nxt, q_r;
  logic [63:0] m9_nxt, m9_r;
  logic [63:0] e2m_nxt, e2m_r;
  logic [63:0] p2_r;

  always_comb begin
    q_nxt   = 64'($signed(p_r) >>> 13);
    m9_nxt  = q_nxt * {{48{p9[15]}}, p9};
    e2m_nxt = p_r * {{48{p8[15]}}, p8};
  end

  always_ff @(posedge clk) begin
    q_r   <= q_nxt;
    m9_r  <= m9_nxt;
    e2m_r <= e2m_nxt;
    p2_r  <= p_r;
  end

  // ------------------------------------------- post 3: partial products
  logic [63:0] ll_nxt, ll_r;
  logic [31:0] lh_nxt, lh_r;
  logic [31:0] hl_nxt, hl_r;
  logic [63:0] e2_nxt, e2_r, e2_s4_r;
  logic [63:0] p3_r, p4_r;

  always_comb begin
    ll_nxt = {32'b0, m9_r[31:0]} * {32'b0, q_r[31:0]};
    lh_nxt = m9_r[31:0] * q_r[63:32];
    hl_nxt = m9_r[63:32] * q_r[31:0];
    e2_nxt = 64'($signed(e2m_r) >>> 19);
  end

  always_ff @(posedge clk) begin
    ll_r <= ll_nxt;
    lh_r <= lh_nxt;
    hl_r <= hl_nxt;
    e2_r <= e2_nxt;
    p3_r <= p2_r;
  end

  // ------------------------------------------------- post 4: combine
  logic [63:0] m_nxt, m_r;

  always_comb begin
    m_nxt = ll_r + {32'(lh_r + hl_r), 32'b0};
  end

  always_ff @(posedge clk) begin
    m_r     <= m_nxt;
    e2_s4_r <= e2_r;
    p4_r    <= p3_r;
  end

  // ------------------------------------------------- post 5: sum
  logic [63:0] s_nxt, s_r;

  always_comb begin
    s_nxt = p4_r + 64'($signed(m_r) >>> 25) + e2_s4_r;
  end

  always_ff @(posedge clk) begin
    s_r <= s_nxt;
  end

  // ------------------------------------------------- post 6: result
  logic [31:0] press_nxt;
  logic [31:0] press_r;
  div_side_t   out_side_r;

  always_comb begin
    press_nxt = 32'($signed(s_r) >>> 8) + 32'({{16{p7[15]}}, p7} << 4);
    if (ps_r[5].dz) begin
      press_nxt = '0;
    end
  end

  always_ff @(posedge clk) begin
    press_r    <= press_nxt;
    out_side_r <= ps_r[5];
  end

  assign out_strobe            = post_vld_r[5];
  assign out_fine_temperature  = {{6{out_side_r.tfine[25]}}, out_side_r.tfine};
  assign out_temperature_centi = out_side_r.temp_c;
  assign out_pressure_q24_8    = press_r;
  assign out_divide_by_zero    = out_side_r.dz;

endmodule
